>>> sv/bped_pkg.sv
package bped_pkg;

    localparam int TIME_W  = 16;
    localparam int HOLD_W  = 32;
    localparam int COUNT_W = 18;
    localparam int MASK_W  = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // Bit positions within the event enable mask.
    localparam int EN_CLICK   = 0;
    localparam int EN_RELEASE = 1;
    localparam int EN_LONG    = 2;
    localparam int EN_SHORT   = 3;
    localparam int EN_REPEAT  = 4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CLICK   = 2'd1,
        PH_PRESS   = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_SHORT_THRESHOLD    = 2'd0,
        REG_REPEAT_INTERVAL    = 2'd1,
        REG_REPEAT_ENTER_DELAY = 2'd2,
        REG_EVENT_ENABLE_MASK  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] short_threshold;
        logic [TIME_W-1:0] repeat_interval;
        logic [TIME_W-1:0] repeat_enter_delay;
        logic [MASK_W-1:0] event_enable_mask;
    } cfg_t;

endpackage

>>> sv/bped_if.sv
interface bped_tick_if import bped_pkg::*;;
    logic              valid;
    logic              ready;
    logic              pressed;
    logic [TIME_W-1:0] elapsed;

    modport source (output valid, pressed, elapsed, input ready);
    modport sink   (input valid, pressed, elapsed, output ready);
endinterface

interface bped_event_if;
    logic valid;
    logic ready;
    logic click_event;
    logic repeat_event;
    logic release_event;
    logic long_event;
    logic short_event;

    modport source (output valid, click_event, repeat_event, release_event,
                    long_event, short_event, input ready);
    modport sink   (input valid, click_event, repeat_event, release_event,
                    long_event, short_event, output ready);
endinterface

>>> sv/bped_cfg.sv
module bped_cfg import bped_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SHORT_THRESHOLD:    cfg_next.short_threshold    = pwdata[TIME_W-1:0];
                REG_REPEAT_INTERVAL:    cfg_next.repeat_interval    = pwdata[TIME_W-1:0];
                REG_REPEAT_ENTER_DELAY: cfg_next.repeat_enter_delay = pwdata[TIME_W-1:0];
                REG_EVENT_ENABLE_MASK:  cfg_next.event_enable_mask  = pwdata[MASK_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SHORT_THRESHOLD:
                prdata = {{(DATA_W-TIME_W){1'b0}}, cfg_reg.short_threshold};
            REG_REPEAT_INTERVAL:
                prdata = {{(DATA_W-TIME_W){1'b0}}, cfg_reg.repeat_interval};
            REG_REPEAT_ENTER_DELAY:
                prdata = {{(DATA_W-TIME_W){1'b0}}, cfg_reg.repeat_enter_delay};
            REG_EVENT_ENABLE_MASK:
                prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_reg.event_enable_mask};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

>>> sv/bped_core.sv
module bped_core import bped_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    bped_tick_if.sink    tick,
    bped_event_if.source events
);

    // Input register
    logic              in_valid_reg;
    logic              in_pressed_reg;
    logic [TIME_W-1:0] in_elapsed_reg;

    // Detector state
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [HOLD_W-1:0]  hold_reg;
    logic [HOLD_W-1:0]  hold_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Result register
    logic out_valid_reg;
    logic click_reg, repeat_reg, release_reg, long_reg, short_reg;
    logic click_next, repeat_next, release_next, long_next, short_next;

    logic               advance;
    logic [HOLD_W:0]    hold_sum;
    logic [COUNT_W:0]   count_diff;
    logic [COUNT_W-1:0] enter_load;
    logic               expired;
    logic [HOLD_W-1:0]  thresh_ext;

    // The work in the input register moves on whenever the result register
    // is free or is being emptied in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || events.ready);
    assign tick.ready = !in_valid_reg || advance;

    assign hold_sum   = {1'b0, hold_reg} + {{(HOLD_W-TIME_W+1){1'b0}}, in_elapsed_reg};
    assign count_diff = {count_reg[COUNT_W-1], count_reg}
                        - {{(COUNT_W-TIME_W+1){1'b0}}, in_elapsed_reg};
    assign enter_load = {{(COUNT_W-TIME_W){1'b0}}, cfg.repeat_enter_delay}
                        + {{(COUNT_W-TIME_W){1'b0}}, cfg.repeat_interval};
    assign expired    = count_diff[COUNT_W] || (count_diff == '0);
    assign thresh_ext = {{(HOLD_W-TIME_W){1'b0}}, cfg.short_threshold};

    always_comb
    begin
        case (phase_reg)
            PH_IDLE:    phase_next = in_pressed_reg ? PH_CLICK : PH_IDLE;
            PH_CLICK:   phase_next = in_pressed_reg ? PH_PRESS : PH_RELEASE;
            PH_PRESS:   phase_next = in_pressed_reg ? PH_PRESS : PH_RELEASE;
            PH_RELEASE: phase_next = in_pressed_reg ? PH_CLICK : PH_IDLE;
            default:    phase_next = PH_IDLE;
        endcase

        hold_next    = hold_reg;
        count_next   = count_reg;
        click_next   = 1'b0;
        repeat_next  = 1'b0;
        release_next = 1'b0;
        long_next    = 1'b0;
        short_next   = 1'b0;

        case (phase_next)
            PH_CLICK:
            begin
                hold_next  = '0;
                count_next = enter_load;
                click_next = cfg.event_enable_mask[EN_CLICK];
            end
            PH_PRESS:
            begin
                hold_next = hold_sum[HOLD_W] ? '1 : hold_sum[HOLD_W-1:0];
                if (cfg.event_enable_mask[EN_REPEAT])
                begin
                    if (expired)
                    begin
                        count_next  = {{(COUNT_W-TIME_W){1'b0}}, cfg.repeat_interval};
                        repeat_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_diff[COUNT_W-1:0];
                    end
                end
            end
            PH_RELEASE:
            begin
                release_next = cfg.event_enable_mask[EN_RELEASE];
                long_next    = cfg.event_enable_mask[EN_LONG] && (hold_reg > thresh_ext);
                short_next   = cfg.event_enable_mask[EN_SHORT] && (hold_reg < thresh_ext);
            end
            default:
            begin
                hold_next = hold_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            hold_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (advance)
            begin
                phase_reg     <= phase_next;
                hold_reg      <= hold_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_pressed_reg <= tick.pressed;
            in_elapsed_reg <= tick.elapsed;
        end
        if (advance)
        begin
            click_reg   <= click_next;
            repeat_reg  <= repeat_next;
            release_reg <= release_next;
            long_reg    <= long_next;
            short_reg   <= short_next;
        end
    end

    assign events.valid         = out_valid_reg;
    assign events.click_event   = click_reg;
    assign events.repeat_event  = repeat_reg;
    assign events.release_event = release_reg;
    assign events.long_event    = long_reg;
    assign events.short_event   = short_reg;

endmodule

>>> sv/button_press_event_detector_top.sv
// Button event detector. Each tick word carries the sampled button level and
// the time that has passed since the previous tick; for every tick word
// exactly one event word comes back, carrying click, repeat, release, long
// and short flags (all zero when nothing happened). A tick word passes
// through an input register and is then evaluated into the result
// register, so one tick word can be accepted every clock cycle while the
// event channel keeps up; the single combinational stage between the two
// registers holds a 32-bit saturating add and an 18-bit countdown
// subtract. Back-pressure on the event channel stalls the tick channel
// once both registers are full. The four registers (short threshold, repeat
// interval, repeat enter delay and event enable mask) sit at byte addresses
// 0, 4, 8 and 12 of the APB port, all reset to zero, and should be written
// only while no tick word is in flight.
module button_press_event_detector_top import bped_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    bped_tick_if.sink         tick,
    bped_event_if.source      events
);

    cfg_t cfg;

    // Register bank: written on the access phase of an APB write.
    bped_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Phase machine, hold timer and repeat countdown, between the input
    // register and the result register.
    bped_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .events (events)
    );

`ifndef NO_ASSERTIONS
    // A click happens on entering click, a repeat only while held, a release
    // only on letting go: no two of these can share one word.
    assert property (@(posedge clk) disable iff (!rst_n)
        events.valid |-> !(events.click_event && (events.repeat_event
                           || events.release_event)) && !(events.repeat_event
                           && events.release_event))
        else $error("click, repeat and release flagged together");

    // Long and short are strict comparisons, so they are never both set.
    assert property (@(posedge clk) disable iff (!rst_n)
        events.valid |-> !(events.long_event && events.short_event))
        else $error("long and short flagged together");

    // The click, repeat, long and short flags must each be allowed by their enable bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        events.valid |-> (!events.click_event || cfg.event_enable_mask[EN_CLICK])
                      && (!events.repeat_event || cfg.event_enable_mask[EN_REPEAT])
                      && (!events.long_event || cfg.event_enable_mask[EN_LONG])
                      && (!events.short_event || cfg.event_enable_mask[EN_SHORT]))
        else $error("event flagged while disabled");

    // Once a tick is taken, an event word is pending after it has passed the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> ##1 events.valid || $past(events.valid))
        else $error("accepted tick produced no event word");
`endif

endmodule
